>>> rtl/hlfr_pkg.sv
// shared types and constants of the header/length frame receiver
`timescale 1ns / 1ps

package hlfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0]  HDR_FIRST_RST  = 8'h5A;
  localparam logic [7:0]  HDR_SECOND_RST = 8'hA5;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] LEN_MIN        = 16'd2;
  localparam logic [16:0] LEN_MAX        = 17'(MAX_PAYLOAD + 2);

  // register index as carried by paddr[2]
  localparam logic REG_HDR_FIRST  = 1'b0;
  localparam logic REG_HDR_SECOND = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_FUNC   = 3'd3,
    PH_OP     = 3'd4,
    PH_DATA   = 3'd5,
    PH_CRC_LO = 3'd6,
    PH_CRC_HI = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  func_code;
    logic [7:0]  op_code;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] frame_length;
    logic [15:0] crc_received;
    logic        crc_ok;
  } result_t;

endpackage

>>> rtl/hlfr_crc.sv
// byte-wide crc-16 update, reflected polynomial, eight shift steps unrolled
`timescale 1ns / 1ps

module hlfr_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ hlfr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> rtl/hlfr_parser.sv
// frame parsing state machine, crc accumulation and result generation
`timescale 1ns / 1ps

module hlfr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          header_first,
  input  logic [7:0]          header_second,
  output logic                res_valid,
  output hlfr_pkg::result_t   res
);

  hlfr_pkg::phase_t              phase, phase_next;
  logic [7:0]                    previous_byte, previous_byte_next;
  logic [15:0]                   declared_length, declared_length_next;
  logic [hlfr_pkg::CNT_W-1:0]    byte_counter, byte_counter_next;
  logic [7:0]                    held_func, held_func_next;
  logic [7:0]                    held_op, held_op_next;
  logic [15:0]                   crc_acc, crc_acc_next;
  logic [7:0]                    crc_low_held, crc_low_held_next;

  logic [15:0]                   crc_seed, crc_in, crc_fed;
  logic [15:0]                   len_full, cnt_ext;
  logic [15:0]                   rc;
  logic [hlfr_pkg::CNT_W-1:0]    cnt_inc;
  logic                          hdr_match, len_bad, cnt_last;

  // crc over the first header byte, then the current byte on top
  hlfr_crc u_crc_seed (
    .crc_in  (hlfr_pkg::CRC_INIT),
    .data    (header_first),
    .crc_out (crc_seed)
  );

  assign crc_in = (phase == hlfr_pkg::PH_HUNT) ? crc_seed : crc_acc;

  hlfr_crc u_crc_byte (
    .crc_in  (crc_in),
    .data    (rx_byte),
    .crc_out (crc_fed)
  );

  assign hdr_match = (previous_byte == header_first) && (rx_byte == header_second);
  assign len_full  = {declared_length[15:8], rx_byte};
  assign len_bad   = (len_full < hlfr_pkg::LEN_MIN) ||
                     ({1'b0, len_full} > hlfr_pkg::LEN_MAX);
  assign cnt_inc   = byte_counter + hlfr_pkg::CNT_W'(1);
  assign cnt_last  = 16'(cnt_inc) >= (declared_length - hlfr_pkg::LEN_MIN);
  assign cnt_ext   = 16'(byte_counter);
  assign rc        = {rx_byte, crc_low_held};

  // next state
  always_comb begin
    phase_next = phase;
    if (fire) begin
      unique case (phase)
        hlfr_pkg::PH_HUNT:   phase_next = hdr_match ? hlfr_pkg::PH_LEN_HI : hlfr_pkg::PH_HUNT;
        hlfr_pkg::PH_LEN_HI: phase_next = hlfr_pkg::PH_LEN_LO;
        hlfr_pkg::PH_LEN_LO: phase_next = len_bad ? hlfr_pkg::PH_HUNT : hlfr_pkg::PH_FUNC;
        hlfr_pkg::PH_FUNC:   phase_next = hlfr_pkg::PH_OP;
        hlfr_pkg::PH_OP: begin
          phase_next = (declared_length == hlfr_pkg::LEN_MIN) ? hlfr_pkg::PH_CRC_LO
                                                               : hlfr_pkg::PH_DATA;
        end
        hlfr_pkg::PH_DATA:   phase_next = cnt_last ? hlfr_pkg::PH_CRC_LO : hlfr_pkg::PH_DATA;
        hlfr_pkg::PH_CRC_LO: phase_next = hlfr_pkg::PH_CRC_HI;
        hlfr_pkg::PH_CRC_HI: phase_next = hlfr_pkg::PH_HUNT;
        default:             phase_next = hlfr_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    previous_byte_next   = previous_byte;
    declared_length_next = declared_length;
    byte_counter_next    = byte_counter;
    held_func_next       = held_func;
    held_op_next         = held_op;
    crc_acc_next         = crc_acc;
    crc_low_held_next    = crc_low_held;
    res_valid            = 1'b0;
    res                  = '0;
    if (fire) begin
      unique case (phase)
        hlfr_pkg::PH_HUNT: begin
          if (hdr_match) begin
            crc_acc_next         = crc_fed;
            declared_length_next = '0;
            byte_counter_next    = '0;
            previous_byte_next   = '0;
          end else begin
            previous_byte_next = rx_byte;
          end
        end
        hlfr_pkg::PH_LEN_HI: begin
          crc_acc_next         = crc_fed;
          declared_length_next = {rx_byte, 8'h00};
        end
        hlfr_pkg::PH_LEN_LO: begin
          crc_acc_next         = crc_fed;
          declared_length_next = len_full;
          if (len_bad) begin
            res_valid          = 1'b1;
            res.kind           = hlfr_pkg::KIND_REJECT;
            res.frame_length   = len_full;
            previous_byte_next = '0;
            byte_counter_next  = '0;
          end
        end
        hlfr_pkg::PH_FUNC: begin
          crc_acc_next   = crc_fed;
          held_func_next = rx_byte;
        end
        hlfr_pkg::PH_OP: begin
          crc_acc_next      = crc_fed;
          held_op_next      = rx_byte;
          byte_counter_next = '0;
        end
        hlfr_pkg::PH_DATA: begin
          crc_acc_next      = crc_fed;
          res_valid         = 1'b1;
          res.kind          = hlfr_pkg::KIND_PAYLOAD;
          res.func_code     = held_func;
          res.op_code       = held_op;
          res.payload_byte  = rx_byte;
          res.payload_index = cnt_ext[7:0];
          res.frame_length  = declared_length;
          byte_counter_next = cnt_inc;
        end
        hlfr_pkg::PH_CRC_LO: begin
          crc_low_held_next = rx_byte;
        end
        hlfr_pkg::PH_CRC_HI: begin
          res_valid          = 1'b1;
          res.kind           = hlfr_pkg::KIND_DONE;
          res.func_code      = held_func;
          res.op_code        = held_op;
          res.frame_length   = declared_length;
          res.crc_received   = rc;
          res.crc_ok         = (rc == crc_acc);
          previous_byte_next = '0;
          byte_counter_next  = '0;
        end
        default: begin
          previous_byte_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hlfr_pkg::PH_HUNT;
      previous_byte   <= '0;
      declared_length <= '0;
      byte_counter    <= '0;
      held_func       <= '0;
      held_op         <= '0;
      crc_acc         <= hlfr_pkg::CRC_INIT;
      crc_low_held    <= '0;
    end else begin
      phase           <= phase_next;
      previous_byte   <= previous_byte_next;
      declared_length <= declared_length_next;
      byte_counter    <= byte_counter_next;
      held_func       <= held_func_next;
      held_op         <= held_op_next;
      crc_acc         <= crc_acc_next;
      crc_low_held    <= crc_low_held_next;
    end
  end

endmodule

>>> rtl/hlfr_out_reg.sv
// result register with valid/ready handshake towards the receiver
`timescale 1ns / 1ps

module hlfr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  hlfr_pkg::result_t  res,
  input  logic               take,
  output logic               out_valid,
  output hlfr_pkg::result_t  out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> rtl/header_length_frame_receiver.sv
// top level of the header/length frame receiver with apb register port
`timescale 1ns / 1ps

// header/length frame receiver
// s_axis side: one received byte per transfer (s_tdata). the block hunts for
// the two header bytes, reads a big-endian length, a function byte, an
// operation byte, length-2 payload bytes and a crc, low byte first.
// m_axis side: one transfer per payload byte (tuser kind payload), one when a
// frame ends (kind done, with received crc and crc-16/modbus match flag) and
// one when the length is below 2 or the payload exceeds MAX_PAYLOAD (kind
// reject, block goes back to hunting). header, non-rejected length, function,
// operation, crc low and hunting bytes give no transfer.
// apb port: header_first at 0x0, header_second at 0x4, written with the
// usual setup and access cycles, pready always high. write only when idle.
// a result appears on m_axis in the cycle after its byte is taken.
// throughput: one byte per cycle while s_tready is high; each byte goes through the crc byte update
// and the parser state logic between the input and the result register.
// s_tready stays high while the result register is empty or being emptied,
// so a stalled receiver holds one result and back-pressures the input.
// reset: synchronous; headers return to 0x5a/0xa5, parser hunts, crc preset
// to 0xffff, result register empties. no clearing pass is needed.

module header_length_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] func_code, [15:8] op_code, [23:16] payload_byte,
                                 // [31:24] payload_index, [47:32] frame_length,
                                 // [63:48] crc_received, [64] crc_ok, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        header_first, header_second;
  logic              cfg_wr, in_fire;
  logic              res_valid;
  hlfr_pkg::result_t res, out_res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= hlfr_pkg::HDR_FIRST_RST;
      header_second <= hlfr_pkg::HDR_SECOND_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hlfr_pkg::REG_HDR_FIRST:  header_first  <= pwdata[7:0];
        hlfr_pkg::REG_HDR_SECOND: header_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hlfr_pkg::REG_HDR_FIRST:  prdata = {24'h0, header_first};
      hlfr_pkg::REG_HDR_SECOND: prdata = {24'h0, header_second};
      default:                  prdata = '0;
    endcase
  end

  // input accepted whenever the result register can take the outcome
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  hlfr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .rx_byte       (s_tdata),
    .header_first  (header_first),
    .header_second (header_second),
    .res_valid     (res_valid),
    .res           (res)
  );

  hlfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .res_valid (res_valid),
    .res       (res),
    .take      (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res)
  );

  // pack the result for the stream
  assign m_tuser = out_res.kind;
  assign m_tdata = {7'h00, out_res.crc_ok, out_res.crc_received, out_res.frame_length,
                    out_res.payload_index, out_res.payload_byte, out_res.op_code,
                    out_res.func_code};

  // a result is only produced for an accepted byte
  assert property (@(posedge clk) disable iff (rst) res_valid |-> in_fire)
    else $error("parser result without an accepted byte");

  // an accepted byte that gives a result shows up on the output next cycle
  assert property (@(posedge clk) disable iff (rst) (in_fire && res_valid) |=> m_tvalid)
    else $error("result lost on its way to the output register");

  // payload and reject transfers never carry crc fields
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != hlfr_pkg::KIND_DONE) |-> (m_tdata[64:48] == '0))
    else $error("crc fields set on a non-completion transfer");

  // output register is empty straight after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule
